// File: sv/htdc_pkg.sv
package htdc_pkg;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StLin,
    StDiv,
    StProd,
    StWait,
    StFinish
  } htdc_state_e;

  typedef enum logic [2:0] {
    RegCalMode    = 3'd0,
    RegCalLowRaw  = 3'd1,
    RegCalHighRaw = 3'd2,
    RegDriveGain  = 3'd3,
    RegMinDrive   = 3'd4,
    RegChecksum   = 3'd5
  } htdc_reg_e;

  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned WordW    = 16;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned TimerW   = 17;
  localparam int unsigned SpanCW   = 9;
  localparam int unsigned LinProdW = 25;

  localparam logic [WordW-1:0]  FastDrive   = 16'h5FFF;
  localparam logic [WordW-1:0]  FaultDelta  = 16'd30;
  localparam logic [WordW-1:0]  FastDelta   = 16'd20;
  localparam logic [WordW-1:0]  LowPointC   = 16'd100;
  localparam logic [SpanCW-1:0] SpanC       = 9'd300;
  localparam logic [WordW-1:0]  LowRawMax   = 16'h0100;
  localparam logic [WordW-1:0]  HighRawMax  = 16'hF000;
  localparam logic [WordW-1:0]  GainMax     = 16'd1000;
  localparam logic [WordW-1:0]  MinDriveMax = 16'hF000;

  localparam logic [WordW-1:0]  RstCalLow   = 16'd177;
  localparam logic [WordW-1:0]  RstCalHigh  = 16'd928;
  localparam logic [WordW-1:0]  RstGain     = 16'd450;
  localparam logic [WordW-1:0]  RstMinDrive = 16'd45;
  localparam logic [WordW-1:0]  RstChecksum = 16'd1600;
  localparam logic [WordW-1:0]  RstLastSp   = 16'hFFFF;

endpackage

// File: sv/heater_temperature_drive_controller.sv
// Channel  Role    Handshake                 Payload
// in       sink    in_valid_i / in_stall_o   sample_raw_i setpoint_i elapsed_ms_i external_error_i
// out      source  out_valid_o / out_stall_i drive_level_o drive_connected_o temperature_o
//                                            calibration_fault_o heating_fault_o
// cfg      sink    cfg_we_i                  cfg_index_i cfg_data_i
//
// Each tick runs through the bit-serial times-300 multiply, then the restoring divider, then the
// two drive multipliers that run side by side, with control states around these steps.
// The block takes one tick at a time; the result beat waits in the output register, and the
// next tick is accepted while it waits.
// A stalled result holds the block in its finish state only when a further result is ready.
// Reset is asynchronous and active low and loads the calibration defaults.
module heater_temperature_drive_controller
  import htdc_pkg::*;
#(
  parameter int unsigned TIMEOUT_MS     = 90000,
  parameter int unsigned MAX_SETPOINT_C = 500
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_index_i,
  input  logic [WordW-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [WordW-1:0]    sample_raw_i,
  input  logic [WordW-1:0]    setpoint_i,
  input  logic [ElapsedW-1:0] elapsed_ms_i,
  input  logic                external_error_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordW-1:0]    drive_level_o,
  output logic                drive_connected_o,
  output logic [WordW-1:0]    temperature_o,
  output logic                calibration_fault_o,
  output logic                heating_fault_o
);

  localparam logic [WordW-1:0]  MaxSp      = WordW'(MAX_SETPOINT_C);
  localparam logic [TimerW-1:0] TimeoutLim = TimerW'(TIMEOUT_MS);

  htdc_state_e state_q, state_d;

  logic              cal_mode_q;
  logic [WordW-1:0]  cal_low_q, cal_high_q, gain_q, mind_q, checksum_q;

  logic [WordW-1:0]  last_sp_q, last_sp_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic              drive_en_q, drive_en_d;
  logic [WordW-1:0]  hold_q, hold_d;
  logic              cal_latch_q, cal_latch_d;
  logic              heat_latch_q, heat_latch_d;
  logic              out_valid_q;
  logic [WordW-1:0]  temp_out_q;

  logic [WordW-1:0]    sample_q, sp_q, temp_q;
  logic [ElapsedW-1:0] elapsed_q;
  logic                ext_q, bad_q, neg_q;

  logic accept, in_stall, lin_start, div_start, prod_start, finish_en;

  logic [WordW-1:0] cfg_sum;
  logic             bad_now;
  logic [WordW-1:0] lo_eff, hi_eff, gain_eff, mind_eff, span, mag;
  logic             neg_now;

  logic                lin_done, div_done, gain_done, floor_done;
  logic [LinProdW-1:0] lin_prod, quo;
  logic [WordW-1:0]    gain_prod, floor_prod;
  logic [LinProdW:0]   pos_sum;
  logic [WordW-1:0]    lin_temp;
  logic [WordW-1:0]    delta;
  logic                below;
  logic [TimerW:0]     timer_sum;
  logic [TimerW-1:0]   timer_sat, timer_run;
  logic                run;
  logic [WordW-1:0]    level;

  assign accept = in_valid_i && !in_stall;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StPrep;
        end
      end
      StPrep:   state_d = StLin;
      StLin: begin
        if (lin_done) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StProd;
        end
      end
      StProd:   state_d = StWait;
      StWait: begin
        if (gain_done && floor_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = StIdle;
        end
      end
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    lin_start  = 1'b0;
    div_start  = 1'b0;
    prod_start = 1'b0;
    finish_en  = 1'b0;
    case (state_q)
      StIdle:   in_stall = 1'b0;
      StPrep:   lin_start = 1'b1;
      StLin:    div_start = lin_done;
      StProd:   prod_start = 1'b1;
      StFinish: finish_en = !out_valid_q || !out_stall_i;
      default: begin
      end
    endcase
  end

  assign cfg_sum = cal_low_q + cal_high_q + gain_q + mind_q;
  assign bad_now = (cfg_sum != checksum_q) || (cal_low_q > LowRawMax) ||
                   (cal_high_q > HighRawMax) || (gain_q > GainMax) ||
                   (mind_q > MinDriveMax);

  assign lo_eff   = bad_q ? '0 : cal_low_q;
  assign hi_eff   = bad_q ? WordW'(1) : cal_high_q;
  assign gain_eff = bad_q ? WordW'(1) : gain_q;
  assign mind_eff = bad_q ? '0 : mind_q;
  assign span     = (hi_eff == lo_eff) ? WordW'(1) : hi_eff - lo_eff;
  assign neg_now  = sample_q < lo_eff;
  assign mag      = neg_now ? lo_eff - sample_q : sample_q - lo_eff;

  htdc_mul #(.AW(WordW), .BW(SpanCW), .PW(LinProdW)) u_mul_lin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lin_start),
    .a_i    (mag),
    .b_i    (SpanC),
    .done_o (lin_done),
    .prod_o (lin_prod)
  );

  htdc_div #(.NW(LinProdW), .DW(WordW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (lin_prod),
    .den_i  (span),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign pos_sum = {1'b0, quo} + (LinProdW + 1)'(LowPointC);

  always_comb begin
    if (neg_q) begin
      lin_temp = (quo >= LinProdW'(LowPointC)) ? '0 : LowPointC - quo[WordW-1:0];
    end else begin
      lin_temp = (|pos_sum[LinProdW:WordW]) ? '1 : pos_sum[WordW-1:0];
    end
  end

  assign below = temp_q < sp_q;
  assign delta = below ? sp_q - temp_q : '0;

  htdc_mul #(.AW(WordW), .BW(WordW), .PW(WordW)) u_mul_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(prod_start),
    .a_i    (delta),
    .b_i    (gain_eff),
    .done_o (gain_done),
    .prod_o (gain_prod)
  );

  htdc_mul #(.AW(WordW), .BW(WordW), .PW(WordW)) u_mul_floor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(prod_start),
    .a_i    (sp_q),
    .b_i    (mind_eff),
    .done_o (floor_done),
    .prod_o (floor_prod)
  );

  assign timer_sum = {1'b0, timer_q} + (TimerW + 1)'(elapsed_q);
  assign timer_sat = timer_sum[TimerW] ? '1 : timer_sum[TimerW-1:0];
  assign timer_run = (last_sp_q != sp_q) ? '0 : timer_sat;

  always_comb begin
    cal_latch_d  = cal_latch_q | bad_q;
    heat_latch_d = heat_latch_q;
    run          = cal_mode_q || (!ext_q && !cal_latch_d && !heat_latch_q);
    last_sp_d    = last_sp_q;
    timer_d      = timer_sat;
    drive_en_d   = 1'b0;
    hold_d       = hold_q;
    level        = gain_prod;
    if (run) begin
      last_sp_d  = sp_q;
      timer_d    = timer_run;
      drive_en_d = sp_q != '0;
      if (below) begin
        if (delta > FaultDelta) begin
          if (timer_run >= TimeoutLim) begin
            heat_latch_d = 1'b1;
          end
        end else begin
          timer_d = '0;
        end
        if (!cal_mode_q && (delta > FastDelta)) begin
          level = FastDrive;
        end
        hold_d = (level < floor_prod) ? floor_prod : level;
      end else begin
        hold_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cal_mode_q   <= 1'b0;
      cal_low_q    <= RstCalLow;
      cal_high_q   <= RstCalHigh;
      gain_q       <= RstGain;
      mind_q       <= RstMinDrive;
      checksum_q   <= RstChecksum;
      last_sp_q    <= RstLastSp;
      timer_q      <= '0;
      drive_en_q   <= 1'b0;
      hold_q       <= '0;
      cal_latch_q  <= 1'b0;
      heat_latch_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (htdc_reg_e'(cfg_index_i))
          RegCalMode:    cal_mode_q <= cfg_data_i[0];
          RegCalLowRaw:  cal_low_q  <= cfg_data_i;
          RegCalHighRaw: cal_high_q <= cfg_data_i;
          RegDriveGain:  gain_q     <= cfg_data_i;
          RegMinDrive:   mind_q     <= cfg_data_i;
          RegChecksum:   checksum_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (finish_en) begin
        last_sp_q    <= last_sp_d;
        timer_q      <= timer_d;
        drive_en_q   <= drive_en_d;
        hold_q       <= hold_d;
        cal_latch_q  <= cal_latch_d;
        heat_latch_q <= heat_latch_d;
        out_valid_q  <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q  <= sample_raw_i;
      sp_q      <= (!cal_mode_q && (setpoint_i > MaxSp)) ? MaxSp : setpoint_i;
      elapsed_q <= elapsed_ms_i;
      ext_q     <= external_error_i;
      bad_q     <= bad_now;
    end
    if (lin_start) begin
      neg_q <= neg_now;
    end
    if (div_done) begin
      temp_q <= cal_mode_q ? sample_q : lin_temp;
    end
    if (finish_en) begin
      temp_out_q <= temp_q;
    end
  end

  assign in_stall_o          = in_stall;
  assign out_valid_o         = out_valid_q;
  assign drive_level_o       = hold_q;
  assign drive_connected_o   = drive_en_q;
  assign temperature_o       = temp_out_q;
  assign calibration_fault_o = cal_latch_q;
  assign heating_fault_o     = heat_latch_q;

endmodule

// File: sv/htdc_mul.sv
module htdc_mul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16,
  parameter int unsigned PW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(BW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [PW-1:0]   acc_q;
  logic [PW-1:0]   a_q;
  logic [BW-1:0]   b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= PW'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[PW-2:0], 1'b0};
      b_q <= {1'b0, b_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: sv/htdc_div.sv
module htdc_div #(
  parameter int unsigned NW = 25,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [NW-1:0]   quo_q;
  logic [DW:0]     shifted;
  logic [DW:0]     diff;
  logic            ge;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: sv/htdc_checker.sv
module htdc_checker
  import htdc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WordW-1:0] drive_level_o,
  input logic             drive_connected_o,
  input logic [WordW-1:0] temperature_o,
  input logic             calibration_fault_o,
  input logic             heating_fault_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_level_o) &&
      $stable(drive_connected_o) && $stable(temperature_o))
    else $error("Stalled result beat changed.");

  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calibration_fault_o |=> calibration_fault_o)
    else $error("Calibration fault flag cleared without reset.");

  a_heat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heating_fault_o |=> heating_fault_o)
    else $error("Heating fault flag cleared without reset.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result beat appeared while no tick was in progress.");

endmodule

bind heater_temperature_drive_controller htdc_checker u_htdc_checker (.*);

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import htdc_pkg::*;

  localparam int unsigned TimeoutMs     = 90000;
  localparam int unsigned MaxSetpointC  = 500;
  localparam int unsigned TimerMax      = 131071;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 80;

  typedef struct {
    bit [15:0] sample;
    bit [15:0] setpoint;
    bit [9:0]  elapsed_ms;
    bit        ext_err;
    bit        wait_empty;
  } tick_t;

  typedef struct {
    bit [15:0] level;
    bit        connected;
    bit [15:0] temp_deg;
    bit        cal_fault;
    bit        heat_fault;
  } drive_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [RegIdxW-1:0]  cfg_index = '0;
  logic [WordW-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [WordW-1:0]    sample_raw = '0;
  logic [WordW-1:0]    setpoint = '0;
  logic [ElapsedW-1:0] elapsed_ms = '0;
  logic                external_error = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WordW-1:0]    drive_level;
  logic                drive_connected;
  logic [WordW-1:0]    temperature;
  logic                calibration_fault;
  logic                heating_fault;

  // Register copies and controller state kept by the predictor.
  bit          cal_mode_r = 1'b0;
  bit [15:0]   low_raw_r = RstCalLow;
  bit [15:0]   high_raw_r = RstCalHigh;
  bit [15:0]   gain_r = RstGain;
  bit [15:0]   min_drive_r = RstMinDrive;
  bit [15:0]   checksum_r = RstChecksum;
  int unsigned sp_hold = RstLastSp;
  int unsigned heat_timer_ms = 0;
  bit          drive_on = 1'b0;
  bit [15:0]   drive_held = '0;
  bit          cal_fault_q = 1'b0;
  bit          heat_fault_q = 1'b0;

  tick_t       pending_q[$];
  drive_t      expected_q[$];
  int unsigned pushed_count = 0;
  int unsigned ticks_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_connected = 0;
  int unsigned cfg_writes = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          saw_heat = 1'b0;
  bit          saw_cal = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_run = 0;
  logic [9:0]  rx_cycles = '0;

  heater_temperature_drive_controller #(
    .TIMEOUT_MS     (TimeoutMs),
    .MAX_SETPOINT_C (MaxSetpointC)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .sample_raw_i        (sample_raw),
    .setpoint_i          (setpoint),
    .elapsed_ms_i        (elapsed_ms),
    .external_error_i    (external_error),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .drive_level_o       (drive_level),
    .drive_connected_o   (drive_connected),
    .temperature_o       (temperature),
    .calibration_fault_o (calibration_fault),
    .heating_fault_o     (heating_fault)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit [15:0] linear_deg(bit [15:0] raw, bit [15:0] lo, bit [15:0] hi);
    bit [15:0] span16;
    longint    span;
    longint    t;
    span16 = hi - lo;
    span = span16;
    if (span == 0) span = 1;
    t = (longint'(raw) - longint'(lo)) * longint'(SpanC);
    t = t / span + longint'(LowPointC);
    if (t < 0) return 16'd0;
    if (t > 65535) return 16'hFFFF;
    return t[15:0];
  endfunction

  function automatic drive_t drive_step(tick_t tk);
    int unsigned lo;
    int unsigned hi;
    int unsigned gain;
    int unsigned mind;
    int unsigned sp;
    int unsigned deg;
    int unsigned delta;
    int unsigned lvl;
    int unsigned flr;
    bit          bad;
    drive_t      r;
    lo = low_raw_r;
    hi = high_raw_r;
    gain = gain_r;
    mind = min_drive_r;
    bad = (((lo + hi + gain + mind) & 32'hFFFF) != checksum_r) || lo > LowRawMax ||
          hi > HighRawMax || gain > GainMax || mind > MinDriveMax;
    if (bad) begin
      lo = 0;
      hi = 1;
      gain = 1;
      mind = 0;
      cal_fault_q = 1'b1;
    end
    heat_timer_ms = heat_timer_ms + tk.elapsed_ms;
    if (heat_timer_ms > TimerMax) heat_timer_ms = TimerMax;
    sp = tk.setpoint;
    if (cal_mode_r) begin
      deg = tk.sample;
    end else begin
      if (sp > MaxSetpointC) sp = MaxSetpointC;
      deg = linear_deg(tk.sample, lo[15:0], hi[15:0]);
    end
    if (cal_mode_r || (!tk.ext_err && !cal_fault_q && !heat_fault_q)) begin
      if (sp_hold != sp) begin
        sp_hold = sp;
        heat_timer_ms = 0;
      end
      drive_on = (sp != 0);
      if (deg < sp) begin
        delta = sp - deg;
        if (delta > FaultDelta) begin
          if (heat_timer_ms >= TimeoutMs) heat_fault_q = 1'b1;
        end else begin
          heat_timer_ms = 0;
        end
        if (!cal_mode_r && delta > FastDelta) lvl = FastDrive;
        else lvl = (delta * gain) & 32'hFFFF;
        flr = (mind * sp) & 32'hFFFF;
        if (lvl < flr) lvl = flr;
        drive_held = lvl[15:0];
      end else begin
        drive_held = '0;
      end
    end else begin
      drive_on = 1'b0;
    end
    r.level = drive_held;
    r.connected = drive_on;
    r.temp_deg = deg[15:0];
    r.cal_fault = cal_fault_q;
    r.heat_fault = heat_fault_q;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    tick_t       tk;
    bit          took;
    bit          next_valid;
    int unsigned roll;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      took = in_valid && !in_stall;
      next_valid = in_valid && !took;
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0 &&
                     (!pending_q[0].wait_empty || (expected_q.size() == 0 && !took))) begin
          tk = pending_q.pop_front();
          sample_raw <= tk.sample;
          setpoint <= tk.setpoint;
          elapsed_ms <= tk.elapsed_ms;
          external_error <= tk.ext_err;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            roll = $urandom_range(0, 9);
            burst_left <= $urandom_range(1, 16);
            gap_left <= (roll < 4) ? 0 : (roll < 7) ? $urandom_range(1, 8) :
                        $urandom_range(9, 90);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: the stall pattern is chosen by the top bits of a free-running cycle counter.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_run <= 0;
      rx_cycles <= '0;
    end else begin
      rx_cycles <= rx_cycles + 1'b1;
      case (rx_cycles[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: begin
          if (rx_run != 0) begin
            rx_run <= rx_run - 1;
          end else begin
            out_stall <= !out_stall;
            rx_run <= $urandom_range(0, 40);
          end
        end
        default: out_stall <= !out_stall;
      endcase
    end
  end

  always @(posedge clk_i) begin
    tick_t  tk;
    drive_t want;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_index)
          RegCalMode:    cal_mode_r = cfg_data[0];
          RegCalLowRaw:  low_raw_r = cfg_data;
          RegCalHighRaw: high_raw_r = cfg_data;
          RegDriveGain:  gain_r = cfg_data;
          RegMinDrive:   min_drive_r = cfg_data;
          RegChecksum:   checksum_r = cfg_data;
          default: ;
        endcase
      end
      quiet_cycles++;
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        n_results++;
        if (drive_connected) n_connected++;
        if (heating_fault) saw_heat = 1'b1;
        if (calibration_fault) saw_cal = 1'b1;
        if (expected_q.size() == 0) begin
          $display("%0t ns: result beat with no tick outstanding, expected none, actual %0d",
                   $time, drive_level);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("drive_level", want.level, drive_level);
          check_field("drive_connected", want.connected, drive_connected);
          check_field("temperature", want.temp_deg, temperature);
          check_field("calibration_fault", want.cal_fault, calibration_fault);
          check_field("heating_fault", want.heat_fault, heating_fault);
        end
      end
      if (in_valid && !in_stall) begin
        quiet_cycles = 0;
        tk.sample = sample_raw;
        tk.setpoint = setpoint;
        tk.elapsed_ms = elapsed_ms;
        tk.ext_err = external_error;
        tk.wait_empty = 1'b0;
        expected_q.push_back(drive_step(tk));
        ticks_taken++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_tick(bit [15:0] s, bit [15:0] sp, bit [9:0] el, bit ext);
    tick_t tk;
    tk.sample = s;
    tk.setpoint = sp;
    tk.elapsed_ms = el;
    tk.ext_err = ext;
    tk.wait_empty = ((pushed_count % 40) == 39);
    pending_q.push_back(tk);
    pushed_count++;
  endtask

  task automatic settle();
    while (!(ticks_taken == pushed_count && expected_q.size() == 0)) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(htdc_reg_e idx, bit [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic load_cal(bit [15:0] lo, bit [15:0] hi, bit [15:0] gain, bit [15:0] mind);
    bit [15:0] sum;
    sum = lo + hi + gain + mind;
    write_reg(RegCalLowRaw, lo);
    write_reg(RegCalHighRaw, hi);
    write_reg(RegDriveGain, gain);
    write_reg(RegMinDrive, mind);
    write_reg(RegChecksum, sum);
  endtask

  function automatic bit [15:0] raw_for_deg(int deg);
    bit [15:0] span16;
    longint    span;
    longint    v;
    span16 = high_raw_r - low_raw_r;
    span = (span16 == 0) ? 1 : span16;
    v = longint'(low_raw_r) + (longint'(deg) - 100) * span / 300;
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  task automatic random_ticks(int unsigned n);
    bit [15:0] sp;
    bit [15:0] s;
    int        near;
    sp = $urandom_range(0, 520);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        if (cal_mode_r) sp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 600) : $urandom;
        else sp = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 520);
      end
      near = int'(sp) + int'($urandom_range(0, 80)) - 40;
      if ($urandom_range(0, 9) < 3) s = $urandom;
      else if (cal_mode_r) s = (near < 0) ? 16'd0 : (near > 65535) ? 16'hFFFF : near[15:0];
      else s = raw_for_deg(near);
      push_tick(s, sp, $urandom_range(0, 1023), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_tick(16'd0, 16'd0, 10'd0, 1'b0);
    push_tick(16'hFFFF, 16'hFFFF, 10'h3FF, 1'b0);
    push_tick(16'd177, 16'd110, 10'd5, 1'b0);
    push_tick(16'd177, 16'd115, 10'd5, 1'b0);
    push_tick(16'd177, 16'd125, 10'd5, 1'b0);
    push_tick(16'd177, 16'd140, 10'd5, 1'b0);
    push_tick(16'd177, 16'd100, 10'd5, 1'b0);
    push_tick(16'd177, 16'd500, 10'd5, 1'b1);
    push_tick(16'd928, 16'd400, 10'd512, 1'b0);
    push_tick(16'd100, 16'h8000, 10'h155, 1'b0);
    push_tick(16'h5555, 16'h00FF, 10'h2AA, 1'b0);
    push_tick(16'hAAAA, 16'h7FFF, 10'h3FF, 1'b1);
    push_tick(16'd200, 16'd109, 10'd0, 1'b0);
    settle();
    load_cal(16'h0040, 16'h0040, 16'd10, 16'd2);
    push_tick(16'h0040, 16'd50, 10'd1, 1'b0);
    push_tick(16'h003F, 16'd200, 10'd1, 1'b0);
    push_tick(16'h0041, 16'd300, 10'd1, 1'b0);
    push_tick(16'hFFFF, 16'd500, 10'd1, 1'b0);
    settle();
    load_cal(16'h0100, 16'h0101, 16'd1000, 16'd0);
    push_tick(16'd0, 16'd300, 10'd1, 1'b0);
    push_tick(16'h0100, 16'd101, 10'd1, 1'b0);
    settle();
    write_reg(RegCalMode, 1'b1);
    load_cal(RstCalLow, RstCalHigh, RstGain, RstMinDrive);
    push_tick(16'hFFFF, 16'hFFFF, 10'd3, 1'b0);
    push_tick(16'd0, 16'hFFFF, 10'd3, 1'b0);
    push_tick(16'd1000, 16'd1025, 10'd3, 1'b1);
    settle();
    write_reg(RegCalMode, 1'b0);

    for (int k = 0; k < 6; k++) begin
      case (k)
        0: load_cal(RstCalLow, RstCalHigh, RstGain, RstMinDrive);
        1: load_cal(16'h0000, 16'hF000, 16'd1000, 16'hF000);
        2: load_cal(16'h0100, 16'h0000, 16'd0, 16'd0);
        default: load_cal($urandom_range(0, 256), $urandom_range(300, 4000),
                          $urandom_range(0, 1000), $urandom_range(0, 200));
      endcase
      random_ticks(30);
      settle();
    end

    write_reg(RegCalMode, 1'b1);
    load_cal($urandom_range(0, 256), $urandom_range(300, 4000), $urandom_range(0, 1000),
             $urandom_range(0, 200));
    random_ticks(120);
    settle();

    // Hold a large error long enough for the heating fault to latch.
    write_reg(RegCalMode, 1'b0);
    load_cal(RstCalLow, RstCalHigh, RstGain, RstMinDrive);
    for (int i = 0; i < 110; i++) begin
      push_tick(16'd177 + $urandom_range(0, 20), 16'd400, $urandom_range(950, 1023), 1'b0);
    end
    random_ticks(20);
    settle();
    write_reg(RegCalMode, 1'b1);
    random_ticks(40);
    settle();

    for (int k = 0; k < 8; k++) begin
      write_reg(RegCalMode, k[0]);
      case (k)
        0: begin
          load_cal(RstCalLow, RstCalHigh, RstGain, RstMinDrive);
          write_reg(RegChecksum, 16'hFFFF);
        end
        1: load_cal(16'hFFFF, 16'd0, 16'd0, 16'd0);
        2: load_cal(16'd0, 16'hFFFF, 16'd0, 16'd0);
        3: load_cal(16'd0, 16'd0, 16'hFFFF, 16'd0);
        4: load_cal(16'd0, 16'd0, 16'd0, 16'hFFFF);
        5: load_cal(16'd0, 16'd0, 16'd0, 16'd0);
        6: load_cal(16'h0101, 16'd928, 16'd450, 16'd45);
        default: load_cal(16'h0100, 16'hF001, 16'd1001, 16'd0);
      endcase
      random_ticks(15);
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d drive results after %0d register writes, %0d with the heater connected.",
             n_results, cfg_writes, n_connected);
    $display("Heating fault seen: %0d, calibration fault seen: %0d, mismatches: %0d.",
             saw_heat, saw_cal, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
